[rtl/sorted_array_priority_queue_defines.svh]
// Assertion macros shared by the sorted array priority queue RTL.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAQ_ASSERT_SAME(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAQ_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

[rtl/saq_pkg.sv]
// Package with constants and types shared by the sorted array priority queue.
package saq_pkg;
   localparam int MAX_ENTRIES = 16;
   localparam int VALUE_BITS  = 32;
   localparam int COUNT_BITS  = $clog2(MAX_ENTRIES + 1);
   localparam int INDEX_BITS  = $clog2(MAX_ENTRIES);
   localparam int CMD_BITS    = 2;

   localparam logic [CMD_BITS-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_QUERY   = 2'd2;

   localparam logic [COUNT_BITS-1:0] CAPACITY_RESET = COUNT_BITS'(MAX_ENTRIES);
   localparam logic signed [VALUE_BITS-1:0] NO_VALUE = '1;

   typedef struct packed {
      logic                           insert;
      logic                           remove;
      logic signed [VALUE_BITS-1:0]   value;
      logic [COUNT_BITS-1:0]          count;
   } cell_ctrl_type;
endpackage

[rtl/saq_cell.sv]
// One storage cell of the sorted queue: holds one entry and shifts with its neighbors.
module saq_cell (
   input  logic                                 clock,
   input  logic [saq_pkg::INDEX_BITS-1:0]       cell_index,
   input  saq_pkg::cell_ctrl_type               ctrl,
   input  logic                                 left_le,
   input  logic signed [saq_pkg::VALUE_BITS-1:0] left_value,
   input  logic signed [saq_pkg::VALUE_BITS-1:0] right_value,
   output logic                                 le,
   output logic signed [saq_pkg::VALUE_BITS-1:0] value
);
   import saq_pkg::*;

   logic signed [VALUE_BITS-1:0] value_ff;
   logic signed [VALUE_BITS-1:0] value_in;
   logic                         occupied;

   assign occupied = {1'b0, cell_index} < ctrl.count;
   assign le       = occupied && (value_ff <= ctrl.value);
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (!le) begin
            value_in = left_le ? ctrl.value : left_value;
         end
      end else if (ctrl.remove) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end
endmodule

[rtl/sorted_array_priority_queue.sv]
// Top level of the sorted array priority queue built from a chain of cells.
//
// Usage: each request transaction on the req_ channel carries a command
// (enqueue, dequeue or query) and a value. Every request yields exactly one
// response transaction on the rsp_ channel, reporting whether the command
// took effect, the removed head, the new head, the count and empty/full flags.
// A request is taken at a clock edge where req_valid is high and req_stall low.
// The cells compare the incoming value against every entry at once and shift
// together, so a command is applied in the cycle it is taken and its
// response appears in the output register in the cycle after. One request per
// cycle is sustained while the receiver keeps rsp_stall low. When the receiver
// stalls a waiting response, req_stall rises and no further request is taken
// until that response has been delivered. The capacity register is written
// through csr_write_enable and csr_write_data; the user must do so only while
// the queue is idle, unenforced by the block. A synchronous reset empties the
// queue, drops any waiting response and sets the capacity to sixteen.
module sorted_array_priority_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [saq_pkg::CMD_BITS-1:0]          req_command,
   input  logic signed [saq_pkg::VALUE_BITS-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_accepted,
   output logic signed [saq_pkg::VALUE_BITS-1:0] rsp_removed_value,
   output logic signed [saq_pkg::VALUE_BITS-1:0] rsp_head_value,
   output logic [saq_pkg::COUNT_BITS-1:0]        rsp_count,
   output logic                                  rsp_empty_res,
   output logic                                  rsp_full_res,
   input  logic                                  csr_write_enable,
   input  logic [saq_pkg::COUNT_BITS-1:0]        csr_write_data
);
   import saq_pkg::*;

   `include "sorted_array_priority_queue_defines.svh"

   logic [COUNT_BITS-1:0]        capacity_ff;
   logic [COUNT_BITS-1:0]        count_ff;
   logic [COUNT_BITS-1:0]        count_in;
   logic [COUNT_BITS-1:0]        eff_capacity;
   logic                         req_accept;
   logic                         do_insert;
   logic                         do_remove;
   cell_ctrl_type                ctrl;
   logic                         le_chain    [MAX_ENTRIES];
   logic signed [VALUE_BITS-1:0] value_chain [MAX_ENTRIES];
   logic signed [VALUE_BITS-1:0] head_in;

   logic                         rsp_valid_ff;
   logic                         accepted_ff;
   logic signed [VALUE_BITS-1:0] removed_ff;
   logic signed [VALUE_BITS-1:0] head_ff;
   logic [COUNT_BITS-1:0]        rsp_count_ff;
   logic                         empty_ff;
   logic                         full_ff;

   always_comb begin
      if (capacity_ff == '0) begin
         eff_capacity = COUNT_BITS'(1);
      end else if (capacity_ff > COUNT_BITS'(MAX_ENTRIES)) begin
         eff_capacity = COUNT_BITS'(MAX_ENTRIES);
      end else begin
         eff_capacity = capacity_ff;
      end
   end

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign do_insert  = req_accept && (req_command == CMD_ENQUEUE) && (count_ff < eff_capacity);
   assign do_remove  = req_accept && (req_command == CMD_DEQUEUE) && (count_ff != '0);

   assign ctrl.insert = do_insert;
   assign ctrl.remove = do_remove;
   assign ctrl.value  = req_value;
   assign ctrl.count  = count_ff;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
         logic                         cell_left_le;
         logic signed [VALUE_BITS-1:0] cell_left_value;
         logic signed [VALUE_BITS-1:0] cell_right_value;
         if (gi == 0) begin : g_first
            assign cell_left_le    = 1'b1;
            assign cell_left_value = req_value;
         end else begin : g_inner
            assign cell_left_le    = le_chain[gi-1];
            assign cell_left_value = value_chain[gi-1];
         end
         if (gi == MAX_ENTRIES - 1) begin : g_last
            assign cell_right_value = value_chain[gi];
         end else begin : g_body
            assign cell_right_value = value_chain[gi+1];
         end
         saq_cell u_cell (
            .clock       (clock),
            .cell_index  (INDEX_BITS'(gi)),
            .ctrl        (ctrl),
            .left_le     (cell_left_le),
            .left_value  (cell_left_value),
            .right_value (cell_right_value),
            .le          (le_chain[gi]),
            .value       (value_chain[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      head_in  = value_chain[0];
      if (do_insert) begin
         count_in = count_ff + COUNT_BITS'(1);
         head_in  = le_chain[0] ? value_chain[0] : req_value;
      end else if (do_remove) begin
         count_in = count_ff - COUNT_BITS'(1);
         head_in  = value_chain[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         count_ff <= count_in;
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         accepted_ff  <= do_insert || do_remove;
         removed_ff   <= do_remove ? value_chain[0] : NO_VALUE;
         head_ff      <= (count_in == '0) ? NO_VALUE : head_in;
         rsp_count_ff <= count_in;
         empty_ff     <= count_in == '0;
         full_ff      <= count_in >= eff_capacity;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = accepted_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_head_value    = head_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_empty_res     = empty_ff;
   assign rsp_full_res      = full_ff;

   `SAQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
      count_ff <= COUNT_BITS'(MAX_ENTRIES), "stored count exceeds the cell chain")
   `SAQ_ASSERT_NEXT(a_insert_count, clock, reset, do_insert,
      count_ff == $past(count_ff) + COUNT_BITS'(1), "enqueue did not grow the count")
   `SAQ_ASSERT_SAME(a_head_sorted, clock, reset, count_ff > COUNT_BITS'(1),
      value_chain[0] <= value_chain[1], "head entries out of order")
   `SAQ_ASSERT_SAME(a_empty_head, clock, reset, rsp_valid_ff && empty_ff,
      head_ff == NO_VALUE && rsp_count_ff == '0, "empty response with a head")
endmodule
